// ----- rtl/core/uqgm_pkg.sv -----
// Shared constants, types and the gamma table generator for the quad merge block.
package uqgm_pkg;

    localparam int GAMMA_FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam int PIXEL_W = 24;
    localparam int CHAN_W = 8;
    localparam int NUM_CHAN = 3;
    localparam int NUM_PIX = 4;
    localparam int LIMIT_W = 9;
    localparam int LEVEL_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [PIXEL_W-1:0] SPECIAL_RED = 24'hFC0000;
    localparam logic [PIXEL_W-1:0] SPECIAL_BLUE = 24'h0034DC;

    localparam logic [LIMIT_W-1:0] RST_RED_LIMIT = 9'd20;
    localparam logic [LIMIT_W-1:0] RST_GREEN_LIMIT = 9'd12;
    localparam logic [LIMIT_W-1:0] RST_BLUE_LIMIT = 9'd50;

    // Pass levels up to this value accept a single pairing diagonal.
    localparam logic [LEVEL_W-1:0] LOOSE_MAX_LEVEL = 2'd1;

    // Channel order inside the block: red is the most significant byte.
    localparam int CH_RED = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_LIMIT = 2'd0,
        CFG_GREEN_LIMIT = 2'd1,
        CFG_BLUE_LIMIT = 2'd2
    } t_cfg_reg;

    // Gamma table entry: (level/255)^2.2 rounded to nearest with frac_bits fraction bits.
    // Finds the largest T with T == 0 or (2T-1)^5 * 255^11 <= 2^(5F+5) * level^11.
    // Evaluated only while the design elaborates.
    function automatic logic [31:0] gamma_entry(input int frac_bits, input int level);
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [255:0] base;
        logic [31:0] lo;
        logic [31:0] cand;
        logic [31:0] top;
        rhs = 256'd1;
        for (int i = 0; i < 11; i++) begin
            rhs = rhs * 256'(level);
        end
        rhs = rhs << (5 * frac_bits + 5);
        top = 32'd1 << frac_bits;
        lo = '0;
        for (int b = frac_bits; b >= 0; b--) begin
            cand = lo | (32'd1 << b);
            if (cand <= top) begin
                base = 256'((cand << 1) - 32'd1);
                lhs = 256'd1;
                for (int i = 0; i < 5; i++) begin
                    lhs = lhs * base;
                end
                for (int i = 0; i < 11; i++) begin
                    lhs = lhs * 256'd255;
                end
                if (lhs <= rhs) begin
                    lo = cand;
                end
            end
        end
        return lo;
    endfunction

endpackage

// ----- rtl/core/uqgm_front.sv -----
// Front end: limit registers, pair classification and per-channel gamma sums.
module uqgm_front #(
    parameter int GAMMA_FRACTION_BITS = uqgm_pkg::GAMMA_FRACTION_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [uqgm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [uqgm_pkg::LIMIT_W-1:0]           i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [uqgm_pkg::PIXEL_W-1:0]           i_pixel_top_left,
    input  logic [uqgm_pkg::PIXEL_W-1:0]           i_pixel_top_right,
    input  logic [uqgm_pkg::PIXEL_W-1:0]           i_pixel_bottom_left,
    input  logic [uqgm_pkg::PIXEL_W-1:0]           i_pixel_bottom_right,
    input  logic [uqgm_pkg::LEVEL_W-1:0]           i_pass_level,
    output logic                                   o_push,
    input  logic                                   i_full,
    output logic [3*(GAMMA_FRACTION_BITS+3):0]     o_push_data
);

    localparam int RomW = GAMMA_FRACTION_BITS + 1;
    localparam int SumW = GAMMA_FRACTION_BITS + 3;

    logic [RomW-1:0] w_rom [256];

    for (genvar gv = 0; gv < 256; gv++) begin : g_rom
        assign w_rom[gv] = RomW'(uqgm_pkg::gamma_entry(GAMMA_FRACTION_BITS, gv));
    end

    logic [uqgm_pkg::LIMIT_W-1:0] r_red_limit;
    logic [uqgm_pkg::LIMIT_W-1:0] r_green_limit;
    logic [uqgm_pkg::LIMIT_W-1:0] r_blue_limit;

    logic                          r_fv;
    logic                          r_f_merged;
    logic [SumW-1:0]               r_f_sum [uqgm_pkg::NUM_CHAN];

    logic [uqgm_pkg::PIXEL_W-1:0]  w_px [uqgm_pkg::NUM_PIX];
    logic [SumW-1:0]               n_sum [uqgm_pkg::NUM_CHAN];
    logic                          w_diag_main;
    logic                          w_diag_anti;
    logic                          w_qualify;
    logic                          w_uniform;
    logic                          w_accept;

    function automatic logic [uqgm_pkg::CHAN_W-1:0] abs_diff(
        input logic [uqgm_pkg::CHAN_W-1:0] x,
        input logic [uqgm_pkg::CHAN_W-1:0] y
    );
        return (x > y) ? (x - y) : (y - x);
    endfunction

    function automatic logic pair_ok(
        input logic [uqgm_pkg::PIXEL_W-1:0] p,
        input logic [uqgm_pkg::PIXEL_W-1:0] q,
        input logic [uqgm_pkg::LIMIT_W-1:0] lim_r,
        input logic [uqgm_pkg::LIMIT_W-1:0] lim_g,
        input logic [uqgm_pkg::LIMIT_W-1:0] lim_b
    );
        logic close;
        logic special;
        close = ({1'b0, abs_diff(p[23:16], q[23:16])} < lim_r)
             && ({1'b0, abs_diff(p[15:8], q[15:8])} < lim_g)
             && ({1'b0, abs_diff(p[7:0], q[7:0])} < lim_b);
        special = (p == uqgm_pkg::SPECIAL_RED && q == uqgm_pkg::SPECIAL_BLUE)
               || (p == uqgm_pkg::SPECIAL_BLUE && q == uqgm_pkg::SPECIAL_RED);
        return close || special;
    endfunction

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_limit <= uqgm_pkg::RST_RED_LIMIT;
            r_green_limit <= uqgm_pkg::RST_GREEN_LIMIT;
            r_blue_limit <= uqgm_pkg::RST_BLUE_LIMIT;
        end else if (i_cfg_valid) begin
            case (uqgm_pkg::t_cfg_reg'(i_cfg_index))
                uqgm_pkg::CFG_RED_LIMIT: begin
                    r_red_limit <= i_cfg_data;
                end
                uqgm_pkg::CFG_GREEN_LIMIT: begin
                    r_green_limit <= i_cfg_data;
                end
                uqgm_pkg::CFG_BLUE_LIMIT: begin
                    r_blue_limit <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_px[0] = i_pixel_top_left;
    assign w_px[1] = i_pixel_top_right;
    assign w_px[2] = i_pixel_bottom_left;
    assign w_px[3] = i_pixel_bottom_right;

    always_comb begin
        for (int c = 0; c < uqgm_pkg::NUM_CHAN; c++) begin
            n_sum[c] = SumW'(w_rom[w_px[0][23 - 8*c -: 8]])
                     + SumW'(w_rom[w_px[1][23 - 8*c -: 8]])
                     + SumW'(w_rom[w_px[2][23 - 8*c -: 8]])
                     + SumW'(w_rom[w_px[3][23 - 8*c -: 8]]);
        end
    end

    assign w_diag_main = pair_ok(i_pixel_top_left, i_pixel_bottom_right,
                                 r_red_limit, r_green_limit, r_blue_limit);
    assign w_diag_anti = pair_ok(i_pixel_top_right, i_pixel_bottom_left,
                                 r_red_limit, r_green_limit, r_blue_limit);
    assign w_qualify = (i_pass_level <= uqgm_pkg::LOOSE_MAX_LEVEL)
                     ? (w_diag_main || w_diag_anti) : (w_diag_main && w_diag_anti);
    assign w_uniform = (i_pixel_top_left == i_pixel_top_right)
                    && (i_pixel_top_left == i_pixel_bottom_left)
                    && (i_pixel_top_left == i_pixel_bottom_right);

    // The front register is a one-beat skid: it takes a new quad whenever it
    // is empty or its current beat moves into the queue.
    assign o_push = r_fv && !i_full;
    assign o_ready = !r_fv || !i_full;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_accept) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f_merged <= w_qualify && !w_uniform;
            for (int c = 0; c < uqgm_pkg::NUM_CHAN; c++) begin
                r_f_sum[c] <= n_sum[c];
            end
        end
    end

    assign o_push_data = {r_f_merged, r_f_sum[uqgm_pkg::CH_RED],
                          r_f_sum[uqgm_pkg::CH_GREEN], r_f_sum[uqgm_pkg::CH_BLUE]};

    a_ready_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_fv && i_full))
        else $error("front stalled without a held beat");

endmodule

// ----- rtl/core/uqgm_queue.sv -----
// Short first-in first-out queue that decouples the front end from the back end.
module uqgm_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = uqgm_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic [PtrW-1:0]  n_wr_ptr;
    logic [PtrW-1:0]  n_rd_ptr;
    logic [CntW-1:0]  n_count;

    assign o_full = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
        end
        n_count = r_count + CntW'(i_push) - CntW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from an empty queue");

endmodule

// ----- rtl/core/uqgm_back.sv -----
// Back end: pipelined inverse gamma search, one result bit per stage, and the output register.
module uqgm_back #(
    parameter int GAMMA_FRACTION_BITS = uqgm_pkg::GAMMA_FRACTION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_job_valid,
    input  logic [3*(GAMMA_FRACTION_BITS+3):0] i_job_data,
    output logic                               o_job_take,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_merged,
    output logic [uqgm_pkg::PIXEL_W-1:0]       o_merged_color
);

    localparam int RomW = GAMMA_FRACTION_BITS + 1;
    localparam int SumW = GAMMA_FRACTION_BITS + 3;
    localparam int NumStages = uqgm_pkg::CHAN_W;

    logic [RomW-1:0] w_rom [256];

    for (genvar gv = 0; gv < 256; gv++) begin : g_rom
        assign w_rom[gv] = RomW'(uqgm_pkg::gamma_entry(GAMMA_FRACTION_BITS, gv));
    end

    // Stage k holds a beat whose result bits above bit (7-k) are settled.
    logic                         r_sv [NumStages];
    logic                         r_sm [NumStages];
    logic [RomW-1:0]              r_sq [NumStages][uqgm_pkg::NUM_CHAN];
    logic [uqgm_pkg::CHAN_W-1:0]  r_sl [NumStages][uqgm_pkg::NUM_CHAN];
    logic [uqgm_pkg::CHAN_W-1:0]  n_sl [NumStages][uqgm_pkg::NUM_CHAN];

    logic                         r_ov;
    logic                         r_om;
    logic [uqgm_pkg::PIXEL_W-1:0] r_oc;

    logic                         w_adv;
    logic [SumW-1:0]              w_job_sum [uqgm_pkg::NUM_CHAN];

    assign w_job_sum[uqgm_pkg::CH_RED] = i_job_data[3*SumW-1 -: SumW];
    assign w_job_sum[uqgm_pkg::CH_GREEN] = i_job_data[2*SumW-1 -: SumW];
    assign w_job_sum[uqgm_pkg::CH_BLUE] = i_job_data[SumW-1 -: SumW];

    // The whole pipeline moves together whenever the output slot frees up.
    assign w_adv = !r_ov || i_ready;
    assign o_job_take = w_adv && i_job_valid;

    always_comb begin
        for (int k = 0; k < NumStages; k++) begin
            for (int c = 0; c < uqgm_pkg::NUM_CHAN; c++) begin
                n_sl[k][c] = r_sl[k][c] | (8'd128 >> k);
                if (w_rom[n_sl[k][c]] > r_sq[k][c]) begin
                    n_sl[k][c] = r_sl[k][c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumStages; k++) begin
                r_sv[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_sv[0] <= i_job_valid;
            for (int k = 1; k < NumStages; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            r_ov <= r_sv[NumStages-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sm[0] <= i_job_data[3*SumW];
            for (int c = 0; c < uqgm_pkg::NUM_CHAN; c++) begin
                // Comparing 4*ROM[v] with the sum equals comparing ROM[v] with sum/4.
                r_sq[0][c] <= w_job_sum[c][SumW-1:2];
                r_sl[0][c] <= '0;
            end
            for (int k = 1; k < NumStages; k++) begin
                r_sm[k] <= r_sm[k-1];
                for (int c = 0; c < uqgm_pkg::NUM_CHAN; c++) begin
                    r_sq[k][c] <= r_sq[k-1][c];
                    r_sl[k][c] <= n_sl[k-1][c];
                end
            end
            r_om <= r_sm[NumStages-1];
            r_oc <= r_sm[NumStages-1]
                  ? {n_sl[NumStages-1][uqgm_pkg::CH_RED],
                     n_sl[NumStages-1][uqgm_pkg::CH_GREEN],
                     n_sl[NumStages-1][uqgm_pkg::CH_BLUE]}
                  : '0;
        end
    end

    assign o_valid = r_ov;
    assign o_merged = r_om;
    assign o_merged_color = r_oc;

    a_zero_when_not_merged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_merged) |-> (o_merged_color == '0))
        else $error("unmerged result carries a color");

    a_take_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |=> r_sv[0])
        else $error("taken job did not enter the first search stage");

endmodule

// ----- rtl/core/undither_quad_gamma_merge.sv -----
// Top level of the dither-quad detector with gamma-correct 2x2 merge.
// An accepted quad beat passes the front register, the queue, the search stages and the output register to o_valid.
// Throughput: one quad per cycle while results are taken; the eight-stage inverse gamma search is fully pipelined.
// A held result freezes the back end; the front register and queue take up to five more beats.
// Reset (i_rst_n, synchronous, active low) empties all stages and the queue and loads
// the limits with red 20, green 12 and blue 50; the gamma table is constant logic.
module undither_quad_gamma_merge #(
    parameter int GAMMA_FRACTION_BITS = uqgm_pkg::GAMMA_FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel: index 0 red limit, 1 green limit, 2 blue limit.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [uqgm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [uqgm_pkg::LIMIT_W-1:0]   i_cfg_data,
    // Quad input channel.
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [uqgm_pkg::PIXEL_W-1:0]   i_pixel_top_left,
    input  logic [uqgm_pkg::PIXEL_W-1:0]   i_pixel_top_right,
    input  logic [uqgm_pkg::PIXEL_W-1:0]   i_pixel_bottom_left,
    input  logic [uqgm_pkg::PIXEL_W-1:0]   i_pixel_bottom_right,
    input  logic [uqgm_pkg::LEVEL_W-1:0]   i_pass_level,
    // Result channel.
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_merged,
    output logic [uqgm_pkg::PIXEL_W-1:0]   o_merged_color
);

    // A queued job is the merge flag followed by the three per-channel sums of
    // four gamma table values, red first.
    localparam int SumW = GAMMA_FRACTION_BITS + 3;
    localparam int JobW = 1 + uqgm_pkg::NUM_CHAN * SumW;

    logic            w_push;
    logic            w_full;
    logic [JobW-1:0] w_push_data;
    logic            w_pop;
    logic            w_empty;
    logic [JobW-1:0] w_pop_data;

    // The front end classifies the quad (pairs on both diagonals, pass level,
    // uniform check) and forms the linear-light sums in the same cycle it
    // accepts the beat. Its output register doubles as a skid stage.
    uqgm_front #(
        .GAMMA_FRACTION_BITS(GAMMA_FRACTION_BITS)
    ) u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_pixel_top_left     (i_pixel_top_left),
        .i_pixel_top_right    (i_pixel_top_right),
        .i_pixel_bottom_left  (i_pixel_bottom_left),
        .i_pixel_bottom_right (i_pixel_bottom_right),
        .i_pass_level         (i_pass_level),
        .o_push               (w_push),
        .i_full               (w_full),
        .o_push_data          (w_push_data)
    );

    // The queue lets the front keep accepting beats while the back end waits
    // on a stalled consumer, and the other way round.
    uqgm_queue #(
        .WIDTH (JobW),
        .DEPTH (uqgm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_empty     (w_empty),
        .o_pop_data  (w_pop_data)
    );

    // The back end searches, one bit per stage, for the largest level whose
    // gamma value times four stays within the channel sum, which is the
    // truncating inverse gamma of the average. Unmerged quads give color 0.
    uqgm_back #(
        .GAMMA_FRACTION_BITS(GAMMA_FRACTION_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (!w_empty),
        .i_job_data     (w_pop_data),
        .o_job_take     (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_merged       (o_merged),
        .o_merged_color (o_merged_color)
    );

endmodule
